// ===== hw/rtl/sorted_store_with_search_macros.svh =====
// Assertion macros shared by the sorted store RTL.
// Each macro expects clk and rst_n to be in scope where it is used.
`ifndef SORTED_STORE_WITH_SEARCH_MACROS_SVH
`define SORTED_STORE_WITH_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define SSWS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted store assertion failed");
`define SSWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted store assertion failed");
`else
`define SSWS_ASSERT(label, ante, cons)
`define SSWS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/ssws_pkg.sv =====
// Package for the sorted store: sizes, mode and kind codes, cell control struct.
// No dependencies; ssws_cell, ssws_chain and sorted_store_with_search import it.
`timescale 1ns / 1ps
package ssws_pkg;
  localparam int DEPTH       = 32;
  localparam int WORD_WIDTH  = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IN_TDATA_W  = ((WORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WORD_WIDTH + 1 + 7) / 8) * 8;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_DUMP   = 2'd2;

  localparam logic [1:0] KIND_SEARCH = 2'd0;
  localparam logic [1:0] KIND_ELEM   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_FULL   = 2'd3;

  typedef struct packed {
    logic insert;
    logic search;
    logic rotate;
  } cell_ctrl_t;
endpackage

// ===== hw/rtl/ssws_cell.sv =====
// One cell of the sorted insertion chain: holds a single word and its valid bit.
// Depends on ssws_pkg.
`timescale 1ns / 1ps
module ssws_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ssws_pkg::cell_ctrl_t ctrl,
  input  ssws_pkg::word_t    key,
  input  ssws_pkg::word_t    left_val,
  input  logic               left_gt,
  input  logic               left_valid,
  input  ssws_pkg::word_t    right_val,
  input  logic               right_valid,
  input  ssws_pkg::word_t    wrap_val,
  output ssws_pkg::word_t    val,
  output logic               valid,
  output logic               gt,
  output logic               match
);
  import ssws_pkg::*;

  word_t val_r, val_nxt;
  logic  valid_r, valid_nxt;
  logic  match_r;

  // An empty cell counts as greater, so a new value lands in the first free place.
  assign gt = ~valid_r | (val_r > key);

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctrl.insert) begin
      valid_nxt = valid_r | left_valid;
      if (gt) begin
        val_nxt = left_gt ? left_val : key;
      end
    end else if (ctrl.rotate) begin
      val_nxt = right_valid ? right_val : wrap_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (ctrl.search) begin
      match_r <= valid_r & (val_r == key);
    end
  end

  assign val   = val_r;
  assign valid = valid_r;
  assign match = match_r;
endmodule

// ===== hw/rtl/ssws_chain.sv =====
// Row of DEPTH cells wired to their neighbours, with the head and match summary.
// Depends on ssws_pkg and ssws_cell.
`timescale 1ns / 1ps
module ssws_chain (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssws_pkg::cell_ctrl_t         ctrl,
  input  ssws_pkg::word_t              key,
  output ssws_pkg::word_t              head,
  output logic [ssws_pkg::DEPTH-1:0]   valid_vec,
  output logic                         found
);
  import ssws_pkg::*;

  word_t            cell_val   [DEPTH];
  logic [DEPTH-1:0] cell_gt;
  logic [DEPTH-1:0] cell_match;
  word_t            left_val_w [DEPTH];
  word_t            right_val_w[DEPTH];
  logic [DEPTH-1:0] left_gt_w;
  logic [DEPTH-1:0] left_valid_w;
  logic [DEPTH-1:0] right_valid_w;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_val_w[i]   = key;
      assign left_gt_w[i]    = 1'b0;
      assign left_valid_w[i] = 1'b1;
    end else begin : g_mid
      assign left_val_w[i]   = cell_val[i-1];
      assign left_gt_w[i]    = cell_gt[i-1];
      assign left_valid_w[i] = valid_vec[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_val_w[i]   = cell_val[0];
      assign right_valid_w[i] = 1'b0;
    end else begin : g_inner
      assign right_val_w[i]   = cell_val[i+1];
      assign right_valid_w[i] = valid_vec[i+1];
    end

    ssws_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .key         (key),
      .left_val    (left_val_w[i]),
      .left_gt     (left_gt_w[i]),
      .left_valid  (left_valid_w[i]),
      .right_val   (right_val_w[i]),
      .right_valid (right_valid_w[i]),
      .wrap_val    (cell_val[0]),
      .val         (cell_val[i]),
      .valid       (valid_vec[i]),
      .gt          (cell_gt[i]),
      .match       (cell_match[i])
    );
  end

  assign head  = cell_val[0];
  assign found = |cell_match;
endmodule

// ===== hw/rtl/sorted_store_with_search.sv =====
// Sorted store with search: load, search and dump transactions over a sorted cell chain.
// Depends on ssws_pkg, ssws_chain and sorted_store_with_search_macros.svh.
//
// The store keeps up to DEPTH signed words in ascending order in a chain of
// cells. On a load, every cell holding a larger value takes its left
// neighbour's word and the new value drops into the gap. A search compares
// the key in every cell at once into each cell's match register; the search
// state moves the answer into the output register once that is free. A dump
// emits one element per cycle while the output register is free, rotating the
// chain through its head, and leaves the store as it was. The input channel is
// held off while a search or dump is in progress and while the output register
// holds a result that is not yet taken.
`timescale 1ns / 1ps
`include "sorted_store_with_search_macros.svh"
module sorted_store_with_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ssws_pkg::IN_TDATA_W-1:0]     in_tdata,   // value
  input  logic [1:0]                          in_tuser,   // mode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ssws_pkg::OUT_TDATA_W-1:0]    out_tdata,  // element, found
  output logic [1:0]                          out_tuser,  // kind
  output logic                                out_tlast
);
  import ssws_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DUMP   = 3'b100
  } state_t;

  state_t     st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] kind_r, kind_nxt;
  word_t      elem_r, elem_nxt;
  logic       found_r, found_nxt;
  logic       last_r, last_nxt;
  word_t      key_r, key_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       rem_r, rem_nxt;

  logic             out_free;
  logic             acc;
  logic             full;
  logic             empty;
  word_t            in_val;
  cell_ctrl_t       ctrl;
  word_t            head;
  logic [DEPTH-1:0] valid_vec;
  logic             found;

  assign out_free  = ~out_valid_r | out_tready;
  assign in_tready = (st_r == ST_IDLE) & out_free;
  assign acc       = in_tvalid & in_tready;
  assign in_val    = word_t'(in_tdata[WORD_WIDTH-1:0]);
  assign full      = count_r == cnt_t'(DEPTH);
  assign empty     = count_r == '0;

  assign ctrl.insert = acc & (in_tuser == MODE_LOAD) & ~full;
  assign ctrl.search = acc & (in_tuser == MODE_SEARCH);
  assign ctrl.rotate = (st_r == ST_DUMP) & out_free;

  ssws_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .key       (in_val),
    .head      (head),
    .valid_vec (valid_vec),
    .found     (found)
  );

  always_comb begin
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    kind_nxt      = kind_r;
    elem_nxt      = elem_r;
    found_nxt     = found_r;
    last_nxt      = last_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_tuser)
            MODE_LOAD: begin
              if (full) begin
                out_valid_nxt = 1'b1;
                kind_nxt      = KIND_FULL;
                elem_nxt      = in_val;
                found_nxt     = 1'b0;
                last_nxt      = 1'b1;
              end else begin
                count_nxt = count_r + cnt_t'(1);
              end
            end
            MODE_SEARCH: begin
              key_nxt = in_val;
              st_nxt  = ST_SEARCH;
            end
            MODE_DUMP: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                kind_nxt      = KIND_EMPTY;
                elem_nxt      = '0;
                found_nxt     = 1'b0;
                last_nxt      = 1'b1;
              end else begin
                rem_nxt = count_r;
                st_nxt  = ST_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_SEARCH;
          elem_nxt      = key_r;
          found_nxt     = found;
          last_nxt      = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_ELEM;
          elem_nxt      = head;
          found_nxt     = 1'b0;
          last_nxt      = rem_r == cnt_t'(1);
          rem_nxt       = rem_r - cnt_t'(1);
          if (rem_r == cnt_t'(1)) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      rem_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    elem_r  <= elem_nxt;
    found_r <= found_nxt;
    last_r  <= last_nxt;
    key_r   <= key_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({found_r, elem_r});
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  `SSWS_ASSERT(a_count_range, 1'b1, count_r <= cnt_t'(DEPTH))
  `SSWS_ASSERT(a_valid_matches_count, 1'b1, cnt_t'($countones(valid_vec)) == count_r)
  `SSWS_ASSERT(a_dump_has_work, st_r == ST_DUMP, (rem_r != '0) && (rem_r <= count_r))
  `SSWS_ASSERT_NEXT(a_load_grows, ctrl.insert, count_r == $past(count_r) + cnt_t'(1))
endmodule
